// ----- src/swrm_pkg.sv -----
// Shared types and constants of the sliding-window rate meter.
package swrm_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned SLOT_MAX_W = 8;

  typedef enum logic [1:0] {
    KIND_SAME,
    KIND_ADV,
    KIND_FULL
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [SLOT_MAX_W-1:0] last_slot;
    logic [SLOT_MAX_W-1:0] new_slot;
    logic [SLOT_MAX_W-1:0] gap;
    logic [DATA_W-1:0]     count;
  } cmd_t;

endpackage

// ----- src/swrm_front.sv -----
// Front end: accepts timestamps, classifies them and works out bucket slots.
module swrm_front #(
  parameter int unsigned WINDOW_SECONDS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [swrm_pkg::DATA_W-1:0]     now_seconds_i,
  input  logic [swrm_pkg::DATA_W-1:0]     event_count_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output swrm_pkg::cmd_t                  push_cmd_o
);

  localparam int unsigned SlotW = $clog2(WINDOW_SECONDS);
  localparam logic [SlotW:0] WinW = (SlotW + 1)'(WINDOW_SECONDS);
  localparam logic [swrm_pkg::DATA_W-1:0] WinD = swrm_pkg::DATA_W'(WINDOW_SECONDS);

  logic [swrm_pkg::DATA_W-1:0] last_q, last_d;
  logic [SlotW-1:0]            last_slot_q, last_slot_d;

  logic                        accept;
  logic                        is_same;
  logic                        is_full;
  logic [swrm_pkg::DATA_W-1:0] gap;
  logic [SlotW:0]              adv_sum;
  logic [SlotW-1:0]            adv_slot;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_same  = now_seconds_i <= last_q;
  assign gap      = now_seconds_i - last_q;
  assign is_full  = !is_same && (gap >= WinD);
  assign adv_sum  = {1'b0, last_slot_q} + {1'b0, gap[SlotW-1:0]};
  assign adv_slot = (adv_sum >= WinW) ? SlotW'(adv_sum - WinW) : adv_sum[SlotW-1:0];

  assign push_o = accept;

  always_comb begin
    push_cmd_o           = '0;
    push_cmd_o.last_slot = swrm_pkg::SLOT_MAX_W'(last_slot_q);
    push_cmd_o.count     = event_count_i;
    if (is_same) begin
      push_cmd_o.kind     = swrm_pkg::KIND_SAME;
      push_cmd_o.new_slot = swrm_pkg::SLOT_MAX_W'(last_slot_q);
    end else if (is_full) begin
      // restart the ring at the current slot, every bucket is cleared anyway
      push_cmd_o.kind     = swrm_pkg::KIND_FULL;
      push_cmd_o.new_slot = swrm_pkg::SLOT_MAX_W'(last_slot_q);
    end else begin
      push_cmd_o.kind     = swrm_pkg::KIND_ADV;
      push_cmd_o.new_slot = swrm_pkg::SLOT_MAX_W'(adv_slot);
      push_cmd_o.gap      = swrm_pkg::SLOT_MAX_W'(gap[SlotW-1:0]);
    end
  end

  always_comb begin
    last_d      = last_q;
    last_slot_d = last_slot_q;
    if (accept && !is_same) begin
      last_d = now_seconds_i;
      if (!is_full) begin
        last_slot_d = adv_slot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      last_slot_q <= '0;
    end else begin
      last_q      <= last_d;
      last_slot_q <= last_slot_d;
    end
  end

endmodule

// ----- src/swrm_queue.sv -----
// Two-entry command queue between the front end and the bucket engine.
module swrm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  swrm_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output swrm_pkg::cmd_t head_o
);

  swrm_pkg::cmd_t ent_q [2];
  logic           wr_q;
  logic           rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ----- src/swrm_back.sv -----
// Bucket engine: bucket memory, running total and skipped-second walk.
module swrm_back #(
  parameter int unsigned WINDOW_SECONDS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  swrm_pkg::cmd_t               q_head_i,
  output logic                         pop_o,
  output logic                         sum_valid_o,
  input  logic                         sum_stall_i,
  output logic [swrm_pkg::SUM_W-1:0]   sum_o
);

  localparam int unsigned SlotW = $clog2(WINDOW_SECONDS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAME,
    ST_ADV_A,
    ST_ADV_B,
    ST_WALK
  } state_e;

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    return (s == SlotW'(WINDOW_SECONDS - 1)) ? '0 : s + 1'b1;
  endfunction

  state_e                          state_q;
  swrm_pkg::cmd_t                  cmd_q;
  logic [swrm_pkg::SUM_W-1:0]      total_q;
  logic                            emit_q;
  logic [WINDOW_SECONDS-1:0]       vld_q;
  logic [SlotW-1:0]                walk_q;
  logic [swrm_pkg::SLOT_MAX_W-1:0] left_q;
  logic                            rd_ok_q;

  logic [swrm_pkg::DATA_W-1:0]     mem [WINDOW_SECONDS];
  logic [swrm_pkg::DATA_W-1:0]     rd_data_q;

  logic                            can_pop;
  logic [SlotW-1:0]                rd_addr;
  logic                            we;
  logic [SlotW-1:0]                wa;
  logic [swrm_pkg::DATA_W-1:0]     wd;
  logic                            emit_set;
  logic [swrm_pkg::DATA_W-1:0]     bucket;
  logic [swrm_pkg::DATA_W:0]       sat_sum;
  logic [swrm_pkg::DATA_W-1:0]     sat_val;
  logic [SlotW-1:0]                c_last;
  logic [SlotW-1:0]                c_new;

  assign can_pop     = !emit_q || !sum_stall_i;
  assign pop_o       = (state_q == ST_IDLE) && !q_empty_i && can_pop;
  assign sum_valid_o = emit_q;
  assign sum_o       = total_q;

  assign c_last  = cmd_q.last_slot[SlotW-1:0];
  assign c_new   = cmd_q.new_slot[SlotW-1:0];
  assign bucket  = rd_ok_q ? rd_data_q : '0;
  assign sat_sum = {1'b0, bucket} + {1'b0, cmd_q.count};
  assign sat_val = sat_sum[swrm_pkg::DATA_W] ? '1 : sat_sum[swrm_pkg::DATA_W-1:0];

  always_comb begin
    rd_addr  = q_head_i.last_slot[SlotW-1:0];
    we       = 1'b0;
    wa       = c_new;
    wd       = cmd_q.count;
    emit_set = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        rd_addr = q_head_i.last_slot[SlotW-1:0];
        if (pop_o && (q_head_i.kind == swrm_pkg::KIND_FULL)) begin
          we       = 1'b1;
          wa       = q_head_i.new_slot[SlotW-1:0];
          wd       = q_head_i.count;
          emit_set = 1'b1;
        end
      end
      ST_SAME: begin
        we       = 1'b1;
        wa       = c_last;
        wd       = sat_val;
        emit_set = 1'b1;
      end
      ST_ADV_A: begin
        rd_addr = c_new;
      end
      ST_ADV_B: begin
        rd_addr  = next_slot(c_last);
        we       = 1'b1;
        emit_set = cmd_q.gap == swrm_pkg::SLOT_MAX_W'(1);
      end
      ST_WALK: begin
        rd_addr  = next_slot(walk_q);
        emit_set = left_q == swrm_pkg::SLOT_MAX_W'(1);
      end
      default: begin
        rd_addr = c_last;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= '0;
      total_q <= '0;
      emit_q  <= 1'b0;
      vld_q   <= '0;
      walk_q  <= '0;
      left_q  <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      rd_ok_q <= vld_q[rd_addr];
      emit_q  <= emit_set || (emit_q && sum_stall_i);
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            cmd_q <= q_head_i;
            unique case (q_head_i.kind)
              swrm_pkg::KIND_FULL: begin
                vld_q   <= WINDOW_SECONDS'(1) << q_head_i.new_slot[SlotW-1:0];
                total_q <= '0;
              end
              swrm_pkg::KIND_SAME: state_q <= ST_SAME;
              swrm_pkg::KIND_ADV:  state_q <= ST_ADV_A;
              default:             state_q <= ST_IDLE;
            endcase
          end
        end
        ST_SAME: begin
          vld_q[c_last] <= 1'b1;
          state_q       <= ST_IDLE;
        end
        ST_ADV_A: begin
          total_q <= total_q + swrm_pkg::SUM_W'(bucket);
          state_q <= ST_ADV_B;
        end
        ST_ADV_B: begin
          total_q      <= total_q - swrm_pkg::SUM_W'(bucket);
          vld_q[c_new] <= 1'b1;
          walk_q       <= next_slot(c_last);
          left_q       <= cmd_q.gap - 1'b1;
          if (cmd_q.gap == swrm_pkg::SLOT_MAX_W'(1)) begin
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          total_q       <= total_q - swrm_pkg::SUM_W'(bucket);
          vld_q[walk_q] <= 1'b0;
          walk_q        <= next_slot(walk_q);
          left_q        <= left_q - 1'b1;
          if (left_q == swrm_pkg::SLOT_MAX_W'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/swrm_rate.sv -----
// Average unit: window total times a fixed reciprocal, plus output register.
module swrm_rate #(
  parameter int unsigned WINDOW_SECONDS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [swrm_pkg::SUM_W-1:0]   sum_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [swrm_pkg::DATA_W-1:0]  average_rate_o,
  output logic [swrm_pkg::SUM_W-1:0]   window_sum_o
);

  localparam int unsigned Div   = WINDOW_SECONDS - 1;
  localparam int unsigned Lsh   = $clog2(Div);
  localparam int unsigned Sh    = swrm_pkg::SUM_W + Lsh;
  localparam logic [63:0] RecipFull = (64'd1 << Sh) / 64'(Div) + 64'd1;
  localparam logic [47:0] Recip = RecipFull[47:0];
  localparam int unsigned ProdW = 88;

  logic                         en;
  logic                         v1_q;
  logic [swrm_pkg::SUM_W-1:0]   sum1_q;
  logic [43:0]                  p_ll_q, p_lh_q, p_hl_q, p_hh_q;
  logic                         out_valid_q;
  logic [swrm_pkg::DATA_W-1:0]  avg_q;
  logic [swrm_pkg::SUM_W-1:0]   win_q;
  logic [ProdW-1:0]             prod;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign average_rate_o = avg_q;
  assign window_sum_o   = win_q;

  assign prod = ProdW'(p_ll_q)
              + (ProdW'(p_lh_q) << 24)
              + (ProdW'(p_hl_q) << 20)
              + (ProdW'(p_hh_q) << 44);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      out_valid_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum1_q <= sum_i;
      p_ll_q <= 44'(sum_i[19:0])  * 44'(Recip[23:0]);
      p_lh_q <= 44'(sum_i[19:0])  * 44'(Recip[47:24]);
      p_hl_q <= 44'(sum_i[39:20]) * 44'(Recip[23:0]);
      p_hh_q <= 44'(sum_i[39:20]) * 44'(Recip[47:24]);
      win_q  <= sum1_q;
      avg_q  <= prod[Sh+swrm_pkg::DATA_W-1:Sh];
    end
  end

endmodule

// ----- src/sliding_window_rate_meter_unit.sv -----
// Sliding-window rate meter: per-second bucket ring with windowed total and average.
// Per item: a same-second item is a read-modify-write, an advance by g seconds walks the
// skipped seconds, a gap of a whole window or more is done at pop; the walk is the worst case.
// Path: queue entry register, bucket engine states, then the reciprocal multiplier registers.
// Reset: buckets empty through per-entry valid bits, total and last second zero, no sweep.
module sliding_window_rate_meter_unit #(
  parameter int unsigned WINDOW_SECONDS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [swrm_pkg::DATA_W-1:0]  now_seconds_i,
  input  logic [swrm_pkg::DATA_W-1:0]  event_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [swrm_pkg::DATA_W-1:0]  average_rate_o,
  output logic [swrm_pkg::SUM_W-1:0]   window_sum_o
);

  logic                       push;
  swrm_pkg::cmd_t             push_cmd;
  logic                       q_full;
  logic                       q_empty;
  logic                       pop;
  swrm_pkg::cmd_t             head;
  logic                       sum_valid;
  logic                       sum_stall;
  logic [swrm_pkg::SUM_W-1:0] sum;

  swrm_front #(
    .WINDOW_SECONDS(WINDOW_SECONDS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .now_seconds_i(now_seconds_i),
    .event_count_i(event_count_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  swrm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .head_o (head)
  );

  swrm_back #(
    .WINDOW_SECONDS(WINDOW_SECONDS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (head),
    .pop_o      (pop),
    .sum_valid_o(sum_valid),
    .sum_stall_i(sum_stall),
    .sum_o      (sum)
  );

  swrm_rate #(
    .WINDOW_SECONDS(WINDOW_SECONDS)
  ) u_rate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (sum_valid),
    .in_stall_o    (sum_stall),
    .sum_i         (sum),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .average_rate_o(average_rate_o),
    .window_sum_o  (window_sum_o)
  );

endmodule
